// ----- design/aoe_pkg.sv -----
// shared widths, constants and index tables for the affine orthogonality energy block
// no dependencies
package aoe_pkg;

   localparam int FRAC_BITS = 28;

   localparam int AW   = 32;          // input vector component
   localparam int KW   = 32;          // stiffness and volume
   localparam int DW   = 2*AW + 2;    // dot product and norm term
   localparam int HW   = DW - 32;     // upper split of a dot product
   localparam int SQW  = 2*DW;        // squared dot product
   localparam int EW   = SQW + 4;     // energy sum before scaling
   localparam int TW   = DW + AW;     // one gradient term
   localparam int GW   = TW + 2;      // gradient sum before scaling
   localparam int EC   = (EW + 31) / 32;
   localparam int GCW  = GW - 64;     // top chunk of a gradient sum
   localparam int PGW  = GCW + 33;
   localparam int EHW  = 32*EC + 32;
   localparam int GHW  = PGW + 64 + 1;
   localparam int EPW  = EHW + 32;
   localparam int GPW  = GHW + 34;
   localparam int OW   = 64;
   localparam int EOW  = 63;
   localparam int NST  = 8;           // register stages inside the datapath

   localparam logic [DW-1:0] ONE_SQ = DW'(1) << (2*FRAC_BITS);
   localparam logic [EPW-1:0] E_HALF = EPW'(1) << (4*FRAC_BITS - 1);
   localparam logic [GPW-1:0] G_HALF = GPW'(1) << (3*FRAC_BITS - 1);

   localparam logic [OW-1:0]  G_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0]  G_MIN = {1'b1, {(OW-1){1'b0}}};
   localparam logic [EOW-1:0] E_MAX = {EOW{1'b1}};

   // dot pairs: three norms then (1,2), (2,3), (1,3)
   localparam int PI [6] = '{0, 1, 2, 0, 1, 0};
   localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};
   // per gradient row: which dot term and which vector feed each of three terms
   localparam int TV [3][3] = '{'{0, 3, 5}, '{1, 4, 3}, '{2, 5, 4}};
   localparam int TA [3][3] = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}};

endpackage

// ----- design/affine_orthogonality_energy.sv -----
// top level: handshake, valid tracking and result register around aoe_datapath
// depends on aoe_pkg and aoe_datapath
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_a1_x .. req_a3_z, req_stiffness, req_volume
//   rsp     | out       | rsp_valid, rsp_stall, rsp_energy, rsp_grad_*, rsp_saturated
//
// one transaction per cycle unless a stalled result holds the pipeline; the result register
// loads after the eight datapath stages, the last one feeding the result register
// the whole pipeline moves as one; a stalled result freezes every stage
// reset clears the valid bits only; no clearing pass
module affine_orthogonality_energy
   import aoe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [AW-1:0] req_a1_x,
   input  logic signed [AW-1:0] req_a1_y,
   input  logic signed [AW-1:0] req_a1_z,
   input  logic signed [AW-1:0] req_a2_x,
   input  logic signed [AW-1:0] req_a2_y,
   input  logic signed [AW-1:0] req_a2_z,
   input  logic signed [AW-1:0] req_a3_x,
   input  logic signed [AW-1:0] req_a3_y,
   input  logic signed [AW-1:0] req_a3_z,
   input  logic [KW-1:0]        req_stiffness,
   input  logic [KW-1:0]        req_volume,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [EOW-1:0]       rsp_energy,
   output logic signed [OW-1:0] rsp_grad_a1_x,
   output logic signed [OW-1:0] rsp_grad_a1_y,
   output logic signed [OW-1:0] rsp_grad_a1_z,
   output logic signed [OW-1:0] rsp_grad_a2_x,
   output logic signed [OW-1:0] rsp_grad_a2_y,
   output logic signed [OW-1:0] rsp_grad_a2_z,
   output logic signed [OW-1:0] rsp_grad_a3_x,
   output logic signed [OW-1:0] rsp_grad_a3_y,
   output logic signed [OW-1:0] rsp_grad_a3_z,
   output logic                 rsp_saturated
);

   logic                 advance;
   logic [NST-1:0]       vld_ff;
   logic                 rsp_valid_ff;
   logic signed [AW-1:0] a_vec [9];
   logic [EOW-1:0]       energy_in;
   logic [OW-1:0]        grad_in [9];
   logic                 sat_in;
   logic [EOW-1:0]       energy_ff;
   logic [OW-1:0]        grad_ff [9];
   logic                 sat_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign a_vec = '{req_a1_x, req_a1_y, req_a1_z, req_a2_x, req_a2_y, req_a2_z,
                    req_a3_x, req_a3_y, req_a3_z};

   aoe_datapath u_datapath (
      .clock     (clock),
      .en        (advance),
      .a_in      (a_vec),
      .stiffness (req_stiffness),
      .volume    (req_volume),
      .energy    (energy_in),
      .grad      (grad_in),
      .saturated (sat_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[NST-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NST-1];
      end
      if (advance) begin
         energy_ff <= energy_in;
         grad_ff   <= grad_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = energy_ff;
   assign rsp_grad_a1_x = grad_ff[0];
   assign rsp_grad_a1_y = grad_ff[1];
   assign rsp_grad_a1_z = grad_ff[2];
   assign rsp_grad_a2_x = grad_ff[3];
   assign rsp_grad_a2_y = grad_ff[4];
   assign rsp_grad_a2_z = grad_ff[5];
   assign rsp_grad_a3_x = grad_ff[6];
   assign rsp_grad_a3_y = grad_ff[7];
   assign rsp_grad_a3_z = grad_ff[8];
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   // a held result freezes every valid bit in flight
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved under stall");

   // clipping with an in-range energy means some gradient sits at a limit
   a_sat_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated && rsp_energy != E_MAX |->
         grad_ff[0] == G_MAX || grad_ff[0] == G_MIN || grad_ff[1] == G_MAX ||
         grad_ff[1] == G_MIN || grad_ff[2] == G_MAX || grad_ff[2] == G_MIN ||
         grad_ff[3] == G_MAX || grad_ff[3] == G_MIN || grad_ff[4] == G_MAX ||
         grad_ff[4] == G_MIN || grad_ff[5] == G_MAX || grad_ff[5] == G_MIN ||
         grad_ff[6] == G_MAX || grad_ff[6] == G_MIN || grad_ff[7] == G_MAX ||
         grad_ff[7] == G_MIN || grad_ff[8] == G_MAX || grad_ff[8] == G_MIN)
      else $error("saturated flag without a clipped value");

   // last stage feeds the result register when the pipeline moves
   a_drain: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[NST-1] |=> rsp_valid)
      else $error("transaction lost at the output");
`endif

endmodule

// ----- design/aoe_datapath.sv -----
// eight-stage arithmetic pipeline: dots, squares, gradient terms, scaling, rounding
// saturation is combinational on the last stage; depends on aoe_pkg
module aoe_datapath
   import aoe_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a_in [9],
   input  logic [KW-1:0]        stiffness,
   input  logic [KW-1:0]        volume,
   output logic [EOW-1:0]       energy,
   output logic [OW-1:0]        grad [9],
   output logic                 saturated
);

   // stage 1
   logic signed [2*AW-1:0] prod_ff [6][3];
   logic signed [AW-1:0]   a1_ff [9];
   logic [2*KW-1:0]        kv1_ff;
   // stage 2
   logic signed [DW-1:0]   v_ff [6];
   logic signed [AW-1:0]   a2_ff [9];
   logic [2*KW-1:0]        kv2_ff;
   // stage 3
   logic signed [HW-1:0]   vhi [6];
   logic signed [32:0]     vlo [6];
   logic signed [2*HW-1:0] hh_ff [6];
   logic signed [HW+32:0]  hl_ff [6];
   logic [63:0]            ll_ff [6];
   logic signed [HW+AW-1:0] th_ff [3][3][3];
   logic signed [AW+32:0]  tl_ff [3][3][3];
   logic [2*KW-1:0]        kv3_ff;
   // stage 4
   logic signed [SQW-1:0]  sq_ff [6];
   logic signed [TW-1:0]   term_ff [3][3][3];
   logic [2*KW-1:0]        kv4_ff;
   // stage 5
   logic [EW-1:0]          e_ff;
   logic signed [GW-1:0]   gs_ff [3][3];
   logic [2*KW-1:0]        kv5_ff;
   // stage 6
   logic [32*EC-1:0]       e_pad;
   logic [63:0]            pe_ff [EC][2];
   logic signed [PGW-1:0]  pg_ff [3][3][3][2];
   // stage 7
   logic [EHW-1:0]         eh_ff [2];
   logic signed [GHW-1:0]  gh_ff [3][3][2];
   // stage 8
   logic [EPW-1:0]         ef;
   logic [EPW-1:0]         er_ff;
   logic signed [GPW-1:0]  gf [3][3];
   logic signed [GPW-1:0]  gr_ff [9];

   logic                   e_sat;
   logic [8:0]             g_sat;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         vhi[k] = v_ff[k][DW-1:32];
         vlo[k] = $signed({1'b0, v_ff[k][31:0]});
      end
      e_pad = (32*EC)'(e_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: component products and k*v
         for (int k = 0; k < 6; k++)
            for (int c = 0; c < 3; c++)
               prod_ff[k][c] <= a_in[PI[k]*3+c] * a_in[PJ[k]*3+c];
         a1_ff  <= a_in;
         kv1_ff <= stiffness * volume;

         // stage 2: dots, norms minus one
         for (int k = 0; k < 6; k++) begin
            v_ff[k] <= DW'(prod_ff[k][0]) + DW'(prod_ff[k][1]) + DW'(prod_ff[k][2])
                       - ((k < 3) ? ONE_SQ : '0);
         end
         a2_ff  <= a1_ff;
         kv2_ff <= kv1_ff;

         // stage 3: split products for squares and gradient terms
         for (int k = 0; k < 6; k++) begin
            hh_ff[k] <= vhi[k] * vhi[k];
            hl_ff[k] <= vhi[k] * vlo[k];
            ll_ff[k] <= v_ff[k][31:0] * v_ff[k][31:0];
         end
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               for (int t = 0; t < 3; t++) begin
                  th_ff[i][c][t] <= vhi[TV[i][t]] * a2_ff[TA[i][t]*3+c];
                  tl_ff[i][c][t] <= vlo[TV[i][t]] * a2_ff[TA[i][t]*3+c];
               end
         kv3_ff <= kv2_ff;

         // stage 4: reassemble
         for (int k = 0; k < 6; k++)
            sq_ff[k] <= (SQW'(hh_ff[k]) << 64) + (SQW'(hl_ff[k]) << 33) + SQW'(ll_ff[k]);
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               for (int t = 0; t < 3; t++)
                  term_ff[i][c][t] <= (TW'(th_ff[i][c][t]) << 32) + TW'(tl_ff[i][c][t]);
         kv4_ff <= kv3_ff;

         // stage 5: energy and gradient sums
         e_ff <= ((EW'(sq_ff[3]) + EW'(sq_ff[4]) + EW'(sq_ff[5])) << 1)
                 + EW'(sq_ff[0]) + EW'(sq_ff[1]) + EW'(sq_ff[2]);
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               gs_ff[i][c] <= GW'(term_ff[i][c][0]) + GW'(term_ff[i][c][1])
                              + GW'(term_ff[i][c][2]);
         kv5_ff <= kv4_ff;

         // stage 6: scale by k*v in 32-bit pieces
         for (int m = 0; m < EC; m++)
            for (int n = 0; n < 2; n++)
               pe_ff[m][n] <= e_pad[32*m +: 32] * kv5_ff[32*n +: 32];
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               for (int n = 0; n < 2; n++) begin
                  pg_ff[i][c][0][n] <= $signed({{(GCW-32){1'b0}}, gs_ff[i][c][31:0]})
                                       * $signed({1'b0, kv5_ff[32*n +: 32]});
                  pg_ff[i][c][1][n] <= $signed({{(GCW-32){1'b0}}, gs_ff[i][c][63:32]})
                                       * $signed({1'b0, kv5_ff[32*n +: 32]});
                  pg_ff[i][c][2][n] <= $signed(gs_ff[i][c][GW-1:64])
                                       * $signed({1'b0, kv5_ff[32*n +: 32]});
               end

         // stage 7: sum pieces per half of k*v
         for (int n = 0; n < 2; n++) begin
            eh_ff[n] <= EHW'(pe_ff[0][n]) + (EHW'(pe_ff[1][n]) << 32)
                        + (EHW'(pe_ff[2][n]) << 64) + (EHW'(pe_ff[3][n]) << 96)
                        + (EHW'(pe_ff[4][n]) << 128);
            for (int i = 0; i < 3; i++)
               for (int c = 0; c < 3; c++)
                  gh_ff[i][c][n] <= GHW'(pg_ff[i][c][0][n])
                                    + (GHW'(pg_ff[i][c][1][n]) << 32)
                                    + (GHW'(pg_ff[i][c][2][n]) << 64);
         end

         // stage 8: join halves and round to nearest
         er_ff <= (ef + E_HALF) >> (4*FRAC_BITS);
         for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++)
               gr_ff[i*3+c] <= ((gf[i][c] <<< 2) + $signed(G_HALF)) >>> (3*FRAC_BITS);
      end
   end

   always_comb begin
      ef = EPW'(eh_ff[0]) + (EPW'(eh_ff[1]) << 32);
      for (int i = 0; i < 3; i++)
         for (int c = 0; c < 3; c++)
            gf[i][c] = GPW'(gh_ff[i][c][0]) + (GPW'(gh_ff[i][c][1]) << 32);
   end

   // clip to output range
   always_comb begin
      e_sat  = |er_ff[EPW-1:EOW];
      energy = e_sat ? E_MAX : er_ff[EOW-1:0];
      for (int k = 0; k < 9; k++) begin
         g_sat[k] = !((&gr_ff[k][GPW-1:OW-1]) || !(|gr_ff[k][GPW-1:OW-1]));
         if (!g_sat[k])
            grad[k] = gr_ff[k][OW-1:0];
         else if (gr_ff[k][GPW-1])
            grad[k] = G_MIN;
         else
            grad[k] = G_MAX;
      end
      saturated = e_sat || (|g_sat);
   end

endmodule
